[rtl/read_length_window_capacity_top_defines.svh]
// assertion macros used by the checker file of the window capacity block
// no dependencies; the including module must provide clk_i and rst_ni
`ifndef READ_LENGTH_WINDOW_CAPACITY_TOP_DEFINES_SVH
`define READ_LENGTH_WINDOW_CAPACITY_TOP_DEFINES_SVH

// same-cycle implication, disabled while in reset
`define RLWC_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("rlwc check failed");

// next-cycle implication, disabled while in reset
`define RLWC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("rlwc check failed");

`endif

[rtl/rlwc_pkg.sv]
// shared types and constants of the read length window capacity block
// no dependencies
`default_nettype none

package rlwc_pkg;

  // fixed field widths and stream packing
  localparam int unsigned ACT_W       = 2;
  localparam int unsigned FIELD_W     = 16;
  localparam int unsigned CAP_W       = 48;
  localparam int unsigned STAT_W      = 2;
  localparam int unsigned IN_DATA_W   = 40;
  localparam int unsigned OUT_DATA_W  = 48;
  localparam int unsigned IN_LEN_LSB  = 0;
  localparam int unsigned IN_VALID_BIT = 16;
  localparam int unsigned IN_WIN_LSB  = 17;

  typedef enum logic [ACT_W-1:0] {
    ACT_ADD   = 2'd0,
    ACT_BUILD = 2'd1,
    ACT_QUERY = 2'd2,
    ACT_NONE  = 2'd3
  } action_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK        = 2'd0,
    ST_TOO_LONG  = 2'd1,
    ST_NOT_BUILT = 2'd2
  } status_e;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_DISPATCH,
    S_ADD_RD,
    S_ADD_WR,
    S_QRY_RD,
    S_SCAN,
    S_DRAIN1,
    S_DRAIN2,
    S_RESP
  } ctrl_state_e;

  // commands from the controller to the datapath
  typedef struct packed {
    logic load;
    logic clr_wr;
    logic scan_step;
    logic add_rd;
    logic add_wr;
    logic qry_rd;
    logic set_ready;
    logic out_load;
  } dp_cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    action_e act;
    logic    do_add;
    logic    do_query;
    logic    ctr_zero;
    logic    ctr_full;
    logic    out_free;
  } dp_stat_t;

endpackage

`default_nettype wire

[rtl/rlwc_ctrl.sv]
// controller state machine of the window capacity block
// depends on rlwc_pkg for state, command and status types
`default_nettype none

module rlwc_ctrl import rlwc_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     s_tvalid_i,
  output logic          s_tready_o,
  output dp_cmd_t       cmd_o,
  input  wire dp_stat_t stat_i
);

  ctrl_state_e state_q, state_d;

  // state register, clearing pass runs first after reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  assign s_tready_o = (state_q == S_IDLE);

  // next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_CLEAR: begin
        cmd_o.clr_wr = 1'b1;
        if (stat_i.ctr_full) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (s_tvalid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        unique case (stat_i.act)
          ACT_ADD:   state_d = stat_i.do_add ? S_ADD_RD : S_RESP;
          ACT_BUILD: state_d = S_SCAN;
          ACT_QUERY: state_d = stat_i.do_query ? S_QRY_RD : S_RESP;
          ACT_NONE:  state_d = S_RESP;
          default:   state_d = S_RESP;
        endcase
      end
      S_ADD_RD: begin
        cmd_o.add_rd = 1'b1;
        state_d      = S_ADD_WR;
      end
      S_ADD_WR: begin
        cmd_o.add_wr = 1'b1;
        state_d      = S_RESP;
      end
      S_QRY_RD: begin
        cmd_o.qry_rd = 1'b1;
        state_d      = S_RESP;
      end
      S_SCAN: begin
        cmd_o.scan_step = 1'b1;
        if (stat_i.ctr_zero) begin
          state_d = S_DRAIN1;
        end
      end
      S_DRAIN1: begin
        state_d = S_DRAIN2;
      end
      S_DRAIN2: begin
        cmd_o.set_ready = 1'b1;
        state_d         = S_RESP;
      end
      S_RESP: begin
        if (stat_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

[rtl/rlwc_datapath.sv]
// datapath: length histogram memory, window table memory, scan pipeline
// and output register; depends on rlwc_pkg
`default_nettype none

module rlwc_datapath import rlwc_pkg::*; #(
  parameter int unsigned LENGTH_BITS = 16,
  parameter int unsigned COUNT_BITS  = 32
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic [IN_DATA_W-1:0]  s_tdata_i,
  input  wire logic [ACT_W-1:0]      s_tuser_i,
  input  wire dp_cmd_t               cmd_i,
  output dp_stat_t                   stat_o,
  output logic                       m_tvalid_o,
  input  wire logic                  m_tready_i,
  output logic [OUT_DATA_W-1:0]      m_tdata_o,
  output logic [STAT_W-1:0]          m_tuser_o
);

  localparam int unsigned DEPTH   = 2 ** LENGTH_BITS;
  localparam logic [31:0] DEPTH_W = 32'(DEPTH);

  // input field decode
  action_e                in_act;
  logic [FIELD_W-1:0]     in_len;
  logic [FIELD_W-1:0]     in_win;
  logic                   in_valid;
  logic [31:0]            len_w;
  logic [31:0]            win_w;
  logic                   too_long;

  assign in_act   = action_e'(s_tuser_i);
  assign in_len   = s_tdata_i[IN_LEN_LSB +: FIELD_W];
  assign in_win   = s_tdata_i[IN_WIN_LSB +: FIELD_W];
  assign in_valid = s_tdata_i[IN_VALID_BIT];
  assign len_w    = 32'(in_len);
  assign win_w    = 32'(in_win);
  assign too_long = (in_act == ACT_ADD) && in_valid && (len_w >= DEPTH_W);

  // registered item
  action_e                act_q;
  logic [LENGTH_BITS-1:0] addr_q;
  status_e                status_q;
  status_e                status_d;
  logic                   do_add_q;
  logic                   do_query_q;
  logic                   table_ready_q;

  always_comb begin
    priority if (too_long) begin
      status_d = ST_TOO_LONG;
    end else if ((in_act == ACT_QUERY) && !table_ready_q) begin
      status_d = ST_NOT_BUILT;
    end else begin
      status_d = ST_OK;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      do_add_q   <= 1'b0;
      do_query_q <= 1'b0;
    end else if (cmd_i.load) begin
      do_add_q   <= (in_act == ACT_ADD) && in_valid && !too_long;
      do_query_q <= (in_act == ACT_QUERY) && table_ready_q && (win_w < DEPTH_W);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      act_q    <= in_act;
      status_q <= status_d;
      addr_q   <= (in_act == ACT_ADD) ? len_w[LENGTH_BITS-1:0] : win_w[LENGTH_BITS-1:0];
    end
  end

  // table ready flag, set at the end of a build
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      table_ready_q <= 1'b0;
    end else if (cmd_i.set_ready) begin
      table_ready_q <= 1'b1;
    end
  end

  // shared address counter: up for the clearing pass, down for the scan
  logic [LENGTH_BITS-1:0] ctr_q;
  logic                   build_start;

  assign build_start = cmd_i.load && (in_act == ACT_BUILD);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctr_q <= '0;
    end else if (build_start) begin
      ctr_q <= '1;
    end else if (cmd_i.clr_wr) begin
      ctr_q <= ctr_q + LENGTH_BITS'(1);
    end else if (cmd_i.scan_step) begin
      ctr_q <= ctr_q - LENGTH_BITS'(1);
    end
  end

  // length histogram memory
  logic [COUNT_BITS-1:0]  cnt_mem [DEPTH];
  logic [COUNT_BITS-1:0]  cnt_rdata_q;
  logic [COUNT_BITS-1:0]  cnt_inc;
  logic [COUNT_BITS-1:0]  cnt_wdata;
  logic [LENGTH_BITS-1:0] cnt_waddr;
  logic [LENGTH_BITS-1:0] cnt_raddr;
  logic                   cnt_we;
  logic                   cnt_re;

  assign cnt_inc   = (cnt_rdata_q == '1) ? cnt_rdata_q : cnt_rdata_q + COUNT_BITS'(1);
  assign cnt_we    = cmd_i.clr_wr || cmd_i.add_wr;
  assign cnt_waddr = cmd_i.clr_wr ? ctr_q : addr_q;
  assign cnt_wdata = cmd_i.clr_wr ? '0 : cnt_inc;
  assign cnt_re    = cmd_i.scan_step || cmd_i.add_rd;
  assign cnt_raddr = cmd_i.scan_step ? ctr_q : addr_q;

  always_ff @(posedge clk_i) begin
    if (cnt_we) begin
      cnt_mem[cnt_waddr] <= cnt_wdata;
    end
    if (cnt_re) begin
      cnt_rdata_q <= cnt_mem[cnt_raddr];
    end
  end

  // scan pipeline: stage one adds the bin count, stage two the running total
  logic                   v1_q, v2_q;
  logic [LENGTH_BITS-1:0] a1_q, a2_q;
  logic [COUNT_BITS-1:0]  reads_q;
  logic [CAP_W-1:0]       entry_q;
  logic [COUNT_BITS:0]    reads_sum;
  logic [COUNT_BITS-1:0]  reads_sat;
  logic [CAP_W:0]         entry_sum;
  logic [CAP_W-1:0]       entry_sat;

  assign reads_sum = {1'b0, reads_q} + {1'b0, cnt_rdata_q};
  assign reads_sat = reads_sum[COUNT_BITS] ? '1 : reads_sum[COUNT_BITS-1:0];
  assign entry_sum = {1'b0, entry_q} + (CAP_W + 1)'(reads_q);
  assign entry_sat = entry_sum[CAP_W] ? '1 : entry_sum[CAP_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= cmd_i.scan_step;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    a1_q <= ctr_q;
    a2_q <= a1_q;
    if (build_start) begin
      reads_q <= '0;
      entry_q <= '0;
    end else begin
      if (v1_q) begin
        reads_q <= reads_sat;
      end
      if (v2_q) begin
        entry_q <= entry_sat;
      end
    end
  end

  // window table memory
  logic [CAP_W-1:0] tbl_mem [DEPTH];
  logic [CAP_W-1:0] tbl_rdata_q;

  always_ff @(posedge clk_i) begin
    if (v2_q) begin
      tbl_mem[a2_q] <= entry_sat;
    end
    if (cmd_i.qry_rd) begin
      tbl_rdata_q <= tbl_mem[addr_q];
    end
  end

  // output register
  logic                  m_tvalid_q;
  logic [CAP_W-1:0]      m_tdata_q;
  status_e               m_tuser_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_tvalid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      m_tvalid_q <= 1'b1;
    end else if (m_tready_i) begin
      m_tvalid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      m_tdata_q <= do_query_q ? tbl_rdata_q : '0;
      m_tuser_q <= status_q;
    end
  end

  assign m_tvalid_o = m_tvalid_q;
  assign m_tdata_o  = m_tdata_q;
  assign m_tuser_o  = m_tuser_q;

  // status towards the controller
  assign stat_o.act      = act_q;
  assign stat_o.do_add   = do_add_q;
  assign stat_o.do_query = do_query_q;
  assign stat_o.ctr_zero = (ctr_q == '0);
  assign stat_o.ctr_full = (ctr_q == '1);
  assign stat_o.out_free = !m_tvalid_q || m_tready_i;

endmodule

`default_nettype wire

[rtl/read_length_window_capacity_top.sv]
// Read length window capacity block.
// Input stream: s_axis_tuser carries the action (add, build, query, none),
// s_axis_tdata the read length, read valid flag and window size. Output
// stream: m_axis_tdata the capacity, m_axis_tuser the status. Every input
// transaction gives exactly one output transaction, in order.
// One item is worked at a time; s_axis_tready is high only when the block
// is free. An add reads its histogram bin and writes it back incremented,
// a query reads the window table, and other no-op items go straight to
// their result. A build scans the histogram from the top bin down, one
// cycle per histogram bin, set by the single read port of the histogram
// memory and the sequencer stepping around its registered read, then
// drains the scan pipeline. The next item is taken the cycle after its
// result is loaded. After reset the histogram memory is cleared one bin
// per cycle, and no item is accepted until it is cleared.
// The result sits in an output register: when the receiver stalls it holds,
// the block may still accept the next item and waits with its result until
// the register is free.
// depends on rlwc_pkg, rlwc_ctrl and rlwc_datapath
`default_nettype none

module read_length_window_capacity_top import rlwc_pkg::*; #(
  parameter int unsigned LENGTH_BITS = 16,
  parameter int unsigned COUNT_BITS  = 32
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  // [15:0] read_length, [16] read_valid, [32:17] window_size, [39:33] zero
  input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,
  // [1:0] action
  input  wire logic [ACT_W-1:0]      s_axis_tuser,
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  // [47:0] capacity
  output logic [OUT_DATA_W-1:0]      m_axis_tdata,
  // [1:0] status
  output logic [STAT_W-1:0]          m_axis_tuser
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // sequencer
  rlwc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid),
    .s_tready_o (s_axis_tready),
    .cmd_o      (cmd),
    .stat_i     (stat)
  );

  // memories, scan pipeline and output register
  rlwc_datapath #(
    .LENGTH_BITS (LENGTH_BITS),
    .COUNT_BITS  (COUNT_BITS)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tdata_i  (s_axis_tdata),
    .s_tuser_i  (s_axis_tuser),
    .cmd_i      (cmd),
    .stat_o     (stat),
    .m_tvalid_o (m_axis_tvalid),
    .m_tready_i (m_axis_tready),
    .m_tdata_o  (m_axis_tdata),
    .m_tuser_o  (m_axis_tuser)
  );

endmodule

`default_nettype wire

[rtl/rlwc_checker.sv]
// port-level checks of the window capacity block, bound to the top level
// depends on rlwc_pkg and read_length_window_capacity_top_defines.svh
`default_nettype none
`include "read_length_window_capacity_top_defines.svh"

module rlwc_checker import rlwc_pkg::*; (
  input wire logic                  clk_i,
  input wire logic                  rst_ni,
  input wire logic                  s_axis_tvalid,
  input wire logic                  s_axis_tready,
  input wire logic                  m_axis_tvalid,
  input wire logic                  m_axis_tready,
  input wire logic [OUT_DATA_W-1:0] m_axis_tdata,
  input wire logic [STAT_W-1:0]     m_axis_tuser
);

  // a stalled result transaction holds its payload
  `RLWC_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))

  // one item at a time: busy in the cycle after an accepted transaction
  `RLWC_ASSERT_NEXT(a_busy_after_accept, s_axis_tvalid && s_axis_tready, !s_axis_tready)

  // any non-ok status comes with zero capacity
  `RLWC_ASSERT_SAME(a_flag_zero_cap, m_axis_tvalid && (m_axis_tuser != ST_OK), m_axis_tdata == '0)

  // a new result only appears while the input side was busy
  `RLWC_ASSERT_SAME(a_result_from_busy, $rose(m_axis_tvalid), !$past(s_axis_tready))

endmodule

bind read_length_window_capacity_top rlwc_checker u_rlwc_checker (.*);

`default_nettype wire
